// ----- hdl/tmee_pkg.sv -----
// Shared constants for the timeout mantissa/exponent encoder.
// Holds the rounding mode codes, the exponent codes and the default count width.
// Depends on nothing.
package tmee_pkg;

    // Default width of the millisecond count.
    localparam int unsigned MS_WIDTH_DEF = 32;

    // Rounding modes as carried on the mode field.
    localparam logic [1:0] MODE_DOWN    = 2'd0;
    localparam logic [1:0] MODE_NEAREST = 2'd1;
    localparam logic [1:0] MODE_UP      = 2'd2;

    // Exponent codes.
    localparam logic [3:0] EXP_START = 4'd10;  // exponent before any reduction
    localparam logic [3:0] EXP_MIN   = 4'd1;   // last finite exponent
    localparam logic [3:0] EXP_INF   = 4'd0;   // infinite timeout

    // Mantissa codes.
    localparam logic [7:0] MANT_MAX   = 8'd255;
    localparam logic [7:0] MANT_CARRY = 8'd64;  // 256 seen one exponent lower

endpackage

// ----- hdl/timeout_mantissa_exponent_encoder.sv -----
// Top level of the timeout mantissa/exponent encoder: a five-stage pipeline.
// Depends on tmee_pkg for mode codes, exponent codes and the default width.
//
// The encoder takes one word per clock cycle and gives each result from the
// stage five register. Stage one scales the millisecond count by 1000 with
// shifts and subtractions and splits off the microsecond fraction, stages
// two to four each perform three of the nine exponent reduction steps (shift
// right by two, exponent down by one), and stage five applies the rounding
// mode and holds the result. A stall on the output holds the whole pipeline.
module timeout_mantissa_exponent_encoder
    import tmee_pkg::*;
#(
    parameter int unsigned MS_WIDTH = MS_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [MS_WIDTH-1:0] i_ms_count,
    input  logic [1:0]          i_mode,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [7:0]          o_mantissa,
    output logic [3:0]          o_exponent
);

    localparam int unsigned PW = MS_WIDTH + 10;  // width of count * 1000
    localparam int unsigned VW = MS_WIDTH;       // width of the scaled value

    // State of one word as it moves through the reduction steps.
    typedef struct packed {
        logic [VW-1:0] val;
        logic [3:0]    ex;
        logic          trunc;
        logic          half;
        logic          last256;
        logic          zero;
        logic [1:0]    mode;
    } t_lp;

    // One reduction step: if the value is 256 or more and the exponent is
    // above one, shift right by two and remember what fell out.
    function automatic t_lp f_step(input t_lp s);
        t_lp r;
        r = s;
        if ((|s.val[VW-1:8]) && (s.ex > EXP_MIN)) begin
            r.ex      = s.ex - 4'd1;
            r.last256 = (s.val == VW'(256));
            r.half    = s.val[1];
            r.trunc   = s.trunc | (|s.val[1:0]);
            r.val     = s.val >> 2;
        end
        return r;
    endfunction

    logic          adv;
    logic [PW-1:0] prod;
    logic          is_down;
    t_lp           n_s1, n_s2, n_s3, n_s4;
    t_lp           r_s1, r_s2, r_s3, r_s4;
    logic [5:1]    r_vld;
    logic [7:0]    n_mantissa, r_mantissa;
    logic [3:0]    n_exponent, r_exponent;

    // The whole pipeline moves unless a finished word is held back.
    assign adv     = !(r_vld[5] && i_stall);
    assign o_stall = !adv;
    assign o_valid = r_vld[5];
    assign o_mantissa = r_mantissa;
    assign o_exponent = r_exponent;

    // Stage one: count * 1000 as (count << 10) - (count << 4) - (count << 3).
    assign prod = (PW'(i_ms_count) << 10) - (PW'(i_ms_count) << 4)
                - (PW'(i_ms_count) << 3);
    assign is_down = (i_mode != MODE_UP) && (i_mode != MODE_NEAREST);

    always_comb begin
        n_s1.val     = prod[PW-1:10];
        n_s1.ex      = EXP_START;
        n_s1.trunc   = |prod[9:0];
        n_s1.half    = prod[9];
        n_s1.last256 = 1'b0;
        n_s1.zero    = (i_ms_count == '0)
                    || ((i_ms_count == MS_WIDTH'(1)) && is_down);
        n_s1.mode    = i_mode;
    end

    // Stages two to four: three reduction steps each.
    assign n_s2 = f_step(f_step(f_step(r_s1)));
    assign n_s3 = f_step(f_step(f_step(r_s2)));
    assign n_s4 = f_step(f_step(f_step(r_s3)));

    // Stage five: rounding and the special cases.
    always_comb begin
        logic       up;
        logic       nearest;
        logic       big;
        logic [7:0] v8;
        up      = (r_s4.mode == MODE_UP);
        nearest = (r_s4.mode == MODE_NEAREST);
        big     = |r_s4.val[VW-1:8];
        v8      = r_s4.val[7:0];
        n_mantissa = v8;
        n_exponent = r_s4.ex;
        priority if (r_s4.zero) begin
            n_mantissa = 8'd0;
            n_exponent = EXP_START;
        end else if (r_s4.last256) begin
            // The value was exactly 256 before the last shift: half is ignored.
            n_mantissa = v8 + {7'd0, up && r_s4.trunc};
        end else if (r_s4.ex == EXP_MIN) begin
            if (up && (big || ((v8 == MANT_MAX) && r_s4.trunc))) begin
                n_mantissa = 8'd0;
                n_exponent = EXP_INF;
            end else if (big || (v8 == MANT_MAX)) begin
                n_mantissa = MANT_MAX;
            end else if ((r_s4.trunc && up) || (r_s4.half && nearest)) begin
                n_mantissa = v8 + 8'd1;
            end
        end else if ((up && r_s4.trunc) || (nearest && r_s4.half)) begin
            // Rounding up out of 255 carries into the next lower exponent.
            if (v8 == MANT_MAX) begin
                n_mantissa = MANT_CARRY;
                n_exponent = r_s4.ex - 4'd1;
            end else begin
                n_mantissa = v8 + 8'd1;
            end
        end else begin
            // Nothing to round: the value stands as it is.
            n_mantissa = v8;
        end
    end

    // Valid bits travel with the words.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[4:1], i_valid};
        end
    end

    // Data registers of all stages.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1       <= n_s1;
            r_s2       <= n_s2;
            r_s3       <= n_s3;
            r_s4       <= n_s4;
            r_mantissa <= n_mantissa;
            r_exponent <= n_exponent;
        end
    end

    // An infinite timeout always carries a zero mantissa.
    a_inf_mant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_exponent == EXP_INF)) |-> (o_mantissa == 8'd0))
        else $error("infinite timeout with nonzero mantissa");

    // The exponent never exceeds its starting value.
    a_exp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_exponent <= EXP_START))
        else $error("exponent out of range");

    // A word in the last reduction stage reaches the output when the pipe moves.
    a_word_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_vld[4]) |=> o_valid)
        else $error("word lost between reduction and rounding");

    // Only rounding up can give an infinite timeout.
    a_inf_only_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_vld[4] && (r_s4.mode != MODE_UP)) |=> (o_exponent != EXP_INF))
        else $error("infinite timeout without rounding up");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the timeout mantissa/exponent encoder.
// Drives millisecond counts and rounding modes, predicts each result in-line
// and compares it with the block's output. Depends on tmee_pkg and the RTL.
module tb;
    import tmee_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int RANDOM_WORDS   = 1330;

    typedef struct packed {
        logic [31:0] ms_count;
        logic [1:0]  mode;
    } t_timeout_req;

    typedef struct packed {
        logic [7:0] mant;
        logic [3:0] expo;
    } t_timeout_code;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_valid    = 1'b0;
    logic [31:0] i_ms_count = '0;
    logic [1:0]  i_mode     = MODE_DOWN;
    logic        i_stall    = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [7:0]  o_mantissa;
    logic [3:0]  o_exponent;

    t_timeout_req  pending_reqs[$];
    t_timeout_code expected_codes[$];
    int            mismatches  = 0;
    int            idle_cycles = 0;
    int            send_wait   = 0;
    int            stall_wait  = 0;
    bit            send_quiet  = 1'b0;
    bit            recv_quiet  = 1'b0;

    timeout_mantissa_exponent_encoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_ms_count (i_ms_count),
        .i_mode     (i_mode),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_mantissa (o_mantissa),
        .o_exponent (o_exponent)
    );

    always #10 i_clk = ~i_clk;

    // Expected encoding of one count: scale to microseconds, reduce the
    // exponent two bits at a time and then round as the mode asks.
    function automatic t_timeout_code encode_timeout(input logic [31:0] count,
                                                     input logic [1:0] mode);
        t_timeout_code code;
        logic [63:0]   prod;
        logic [63:0]   val;
        logic [63:0]   last_val;
        logic [3:0]    ex;
        logic          trunc;
        logic          half;
        logic          up;
        logic          nearest;
        logic          down;
        up        = (mode == MODE_UP);
        nearest   = (mode == MODE_NEAREST);
        down      = !up && !nearest;
        code.mant = '0;
        code.expo = EXP_START;
        if (count == 0 || (count == 1 && down)) begin
            return code;
        end
        prod     = 64'(count) * 64'd1000;
        trunc    = (prod[9:0] != 0);
        half     = prod[9];
        val      = prod >> 10;
        last_val = '0;
        ex       = EXP_START;
        while (val >= 256 && ex > EXP_MIN) begin
            ex       = ex - 4'd1;
            last_val = val;
            half     = val[1];
            if (val[1:0] != 0) begin
                trunc = 1'b1;
            end
            val = val >> 2;
        end
        // A value of exactly 256 before the last shift ignores the half bit.
        if (last_val == 256) begin
            code.mant = 8'(val + ((up && trunc) ? 1 : 0));
            code.expo = ex;
            return code;
        end
        // At the lowest exponent the value saturates, becomes infinite or is rounded.
        if (ex == EXP_MIN) begin
            code.expo = EXP_MIN;
            if (up && (val >= 256 || (val == 255 && trunc))) begin
                code.mant = '0;
                code.expo = EXP_INF;
            end else if (val >= 255) begin
                code.mant = MANT_MAX;
            end else if ((trunc && up) || (half && nearest)) begin
                code.mant = 8'(val + 1);
            end else begin
                code.mant = 8'(val);
            end
            return code;
        end
        code.mant = 8'(val);
        code.expo = ex;
        if (down || (nearest && !half) || (up && !trunc)) begin
            return code;
        end
        // Rounding 255 upwards carries into the next exponent down.
        if (val == 255) begin
            code.mant = MANT_CARRY;
            code.expo = ex - 4'd1;
        end else begin
            code.mant = 8'(val + 1);
        end
        return code;
    endfunction

    function automatic int draw_wait(input bit quiet);
        return quiet ? 0 : int'($urandom_range(0, 12));
    endfunction

    function automatic logic [1:0] draw_mode();
        if ($urandom_range(0, 49) == 0) begin
            return 2'd3;
        end
        return 2'($urandom_range(MODE_DOWN, MODE_UP));
    endfunction

    // Random, shifted-down or small counts, or counts near the interesting reduction
    // points: 254, 255 and 256 scaled up by a power of four, give or take two ms.
    function automatic logic [31:0] draw_count();
        logic [63:0] target;
        logic [63:0] base;
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $urandom >> $urandom_range(0, 31);
            2: return 32'($urandom_range(0, 300));
            default: begin
                target = 64'(254 + $urandom_range(0, 2)) << (2 * $urandom_range(0, 8));
                base   = (target * 1024 + 999) / 1000;
                return 32'(base + $urandom_range(0, 4) - 2);
            end
        endcase
    endfunction

    task automatic add_req(input logic [31:0] count, input logic [1:0] mode);
        t_timeout_req req;
        req.ms_count = count;
        req.mode     = mode;
        pending_reqs.push_back(req);
    endtask

    // Driver: presents the head of the pending queue, holds it while stalled
    // and waits a drawn number of cycles after each accepted word.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_codes.push_back(encode_timeout(i_ms_count, i_mode));
                void'(pending_reqs.pop_front());
                if ($urandom_range(0, 39) == 0) begin
                    send_quiet = !send_quiet;
                end
                send_wait = draw_wait(send_quiet);
            end
            if (!(i_valid && o_stall)) begin
                if (send_wait == 0 && pending_reqs.size() != 0) begin
                    i_valid    <= 1'b1;
                    i_ms_count <= pending_reqs[0].ms_count;
                    i_mode     <= pending_reqs[0].mode;
                end else begin
                    i_valid <= 1'b0;
                    if (send_wait > 0) begin
                        send_wait--;
                    end
                end
            end
        end
    end

    // Monitor: checks each accepted result against the oldest expectation,
    // then stalls the output for a drawn number of cycles.
    always @(posedge i_clk) begin
        t_timeout_code want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_codes.size() == 0) begin
                    $display("%0t: unexpected result mantissa %0d exponent %0d",
                             $time, o_mantissa, o_exponent);
                    mismatches++;
                end else begin
                    want = expected_codes.pop_front();
                    if (o_mantissa !== want.mant) begin
                        $display("%0t: mantissa expected %0d actual %0d",
                                 $time, want.mant, o_mantissa);
                        mismatches++;
                    end
                    if (o_exponent !== want.expo) begin
                        $display("%0t: exponent expected %0d actual %0d",
                                 $time, want.expo, o_exponent);
                        mismatches++;
                    end
                end
                if ($urandom_range(0, 39) == 0) begin
                    recv_quiet = !recv_quiet;
                end
                stall_wait = draw_wait(recv_quiet);
            end
            if (stall_wait > 0) begin
                i_stall <= 1'b1;
                stall_wait--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog: ends the run if no word moves on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        // Zero and one millisecond in every mode.
        for (int m = MODE_DOWN; m <= MODE_UP; m++) begin
            add_req(32'd0, 2'(m));
            add_req(32'd1, 2'(m));
        end
        // Exactly 256 before the last shift, and 255 rounding into the next exponent.
        for (int m = MODE_DOWN; m <= MODE_UP; m++) begin
            add_req(32'd263, 2'(m));
            add_req(32'd262, 2'(m));
        end
        add_req(32'd1049, MODE_UP);
        // Lowest exponent: 255 with bits truncated, and far beyond the range.
        add_req(32'd68451042, MODE_DOWN);
        add_req(32'd68451042, MODE_UP);
        for (int m = MODE_DOWN; m <= MODE_UP; m++) begin
            add_req(32'hFFFF_FFFF, 2'(m));
        end
        add_req(32'd68182606, MODE_NEAREST);
        // The undefined mode rounds down.
        add_req(32'd999, 2'd3);
        add_req(32'h5555_5555, MODE_NEAREST);
        add_req(32'hAAAA_AAAA, MODE_UP);
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            add_req(draw_count(), draw_mode());
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || expected_codes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
